// ===== rtl/whc_pkg.sv =====
// Shared types and constants of the windowed half-wave correlator.
`timescale 1ns / 1ps
`default_nettype none
package whc_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int MAG_W      = 16;
  localparam int IDX_W      = 18;
  localparam int WAVE_CFG_W = 13;
  localparam int FREQ_W     = 15;
  localparam int FLEN_CFG_W = 21;
  localparam int CFG_DATA_W = 21;
  localparam int CFG_IDX_W  = 2;

  // Scale divisor of the result and the bits it needs.
  localparam int SCALE_DIV  = 1000000;
  localparam int SCALE_W    = 20;
  localparam int MIN_WAVE   = 4;

  localparam logic [CFG_IDX_W-1:0] REG_ONE_WAVE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FREQ_HZ   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_LEN = 2'd2;

  localparam logic [WAVE_CFG_W-1:0] RST_ONE_WAVE  = 13'd441;
  localparam logic [FREQ_W-1:0]     RST_FREQ_HZ   = 15'd100;
  localparam logic [FLEN_CFG_W-1:0] RST_FRAME_LEN = 21'd1000;

  // Window queue between the accumulators and the scaling unit.
  localparam int QDEPTH = 4;
  localparam int QP_W   = 2;
  localparam int QC_W   = 3;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       frame_start;
  } in_item_t;

  typedef struct packed {
    logic [MAG_W-1:0] magnitude;
    logic [IDX_W-1:0] window_index;
  } out_item_t;

  typedef struct packed {
    logic            empty;
    logic [QC_W-1:0] count;
  } q_stat_t;

endpackage
`default_nettype wire

// ===== rtl/whc_fifo.sv =====
// Short window queue between the front accumulators and the back scaling unit.
`timescale 1ns / 1ps
`default_nettype none
module whc_fifo #(
  parameter int DATA_W = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire logic [DATA_W-1:0] push_data_i,
  input  wire logic              pop_i,
  output logic [DATA_W-1:0]      pop_data_o,
  output whc_pkg::q_stat_t       stat_o
);
  import whc_pkg::*;

  logic [DATA_W-1:0] mem_q [QDEPTH];
  logic [QP_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QC_W-1:0]   count_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QP_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QP_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + QC_W'(1);
      end else if (!push_i && pop_i) begin
        count_q <= count_q - QC_W'(1);
      end
    end
  end

  assign pop_data_o   = mem_q[rd_ptr_q];
  assign stat_o.empty = (count_q == '0);
  assign stat_o.count = count_q;

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q < QC_W'(QDEPTH)))
    else $error("window queue written while full");

  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (count_q != '0))
    else $error("window queue read while empty");

endmodule
`default_nettype wire

// ===== rtl/whc_front.sv =====
// Front part: takes samples, keeps frame and window position, accumulates weighted sums.
`timescale 1ns / 1ps
`default_nettype none
module whc_front #(
  parameter int MAX_WAVE  = 4096,
  parameter int MAX_FRAME = 1048576,
  localparam int WV_W   = $clog2(MAX_WAVE + 1),
  localparam int FP_W   = $clog2(MAX_FRAME + 1),
  localparam int SUM_W  = 2 * $clog2(MAX_WAVE) + 19,
  localparam int DIFF_W = SUM_W + 1
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire whc_pkg::in_item_t        in_data_i,
  input  wire logic [WV_W-1:0]          wave_i,
  input  wire logic [FP_W-1:0]          flen_i,
  input  wire whc_pkg::q_stat_t         q_stat_i,
  output logic                          push_o,
  output logic [whc_pkg::IDX_W+DIFF_W-1:0] push_data_o
);
  import whc_pkg::*;

  localparam int PH_W = $clog2(MAX_WAVE);
  localparam int AW   = WV_W + 1;
  localparam int CW   = ((FP_W > WV_W) ? FP_W : WV_W) + 2;

  logic [FP_W-1:0]         frame_pos_q, frame_pos_d;
  logic [PH_W-1:0]         phase_q, phase_d;
  logic signed [SUM_W-1:0] s1_q, s1_d, s2_q, s2_d;
  logic [IDX_W-1:0]        wcount_q, wcount_d;
  logic                    fin_vld_q, fin_vld_d;
  logic signed [SUM_W-1:0] fin1_q, fin2_q;
  logic [IDX_W-1:0]        fin_idx_q;

  logic                    accept, fs, live, in_first, closing, emit_ok;
  logic [FP_W-1:0]         pos_cur;
  logic [PH_W-1:0]         phase_cur;
  logic signed [SUM_W-1:0] s1_cur, s2_cur, prodx;
  logic [IDX_W-1:0]        wcount_cur;
  logic [AW-1:0]           half, quarter, ph, p, weight, ph_inc;
  logic signed [16+AW:0]   prod;
  logic [CW-1:0]           start;
  logic [QC_W:0]           used;
  logic signed [DIFF_W-1:0] diff;

  assign used       = {1'b0, q_stat_i.count} + (QC_W + 1)'(fin_vld_q);
  assign in_ready_o = (used < (QC_W + 1)'(QDEPTH));
  assign accept     = in_valid_i && in_ready_o;
  assign fs         = in_data_i.frame_start;

  // A frame start restarts everything before this sample is counted.
  assign pos_cur    = fs ? '0 : frame_pos_q;
  assign phase_cur  = fs ? '0 : phase_q;
  assign s1_cur     = fs ? '0 : s1_q;
  assign s2_cur     = fs ? '0 : s2_q;
  assign wcount_cur = fs ? '0 : wcount_q;
  assign live       = (pos_cur < flen_i);

  assign half     = AW'(wave_i >> 1);
  assign quarter  = AW'(wave_i >> 2);
  assign ph       = AW'(phase_cur);
  assign in_first = (ph < half);
  assign p        = in_first ? ph : ph - half;
  assign ph_inc   = ph + AW'(1);
  assign closing  = (ph_inc >= (half << 1));

  always_comb begin
    priority if (p < quarter) begin
      weight = p;
    end else if (p < half) begin
      weight = half - p;
    end else begin
      weight = '0;
    end
  end

  assign prod  = in_data_i.sample * $signed({1'b0, weight});
  assign prodx = SUM_W'(prod);

  assign start   = (CW'(phase_cur) <= CW'(pos_cur)) ? CW'(pos_cur) - CW'(phase_cur) : '0;
  assign emit_ok = ((start + CW'(wave_i) + CW'(half)) < CW'(flen_i));

  always_comb begin
    frame_pos_d = frame_pos_q;
    phase_d     = phase_q;
    s1_d        = s1_q;
    s2_d        = s2_q;
    wcount_d    = wcount_q;
    fin_vld_d   = 1'b0;
    if (accept) begin
      frame_pos_d = pos_cur;
      phase_d     = phase_cur;
      s1_d        = s1_cur;
      s2_d        = s2_cur;
      wcount_d    = wcount_cur;
      if (live) begin
        frame_pos_d = pos_cur + FP_W'(1);
        if (closing) begin
          phase_d   = '0;
          s1_d      = '0;
          s2_d      = '0;
          wcount_d  = wcount_cur + IDX_W'(1);
          fin_vld_d = emit_ok;
        end else begin
          phase_d = ph_inc[PH_W-1:0];
          s1_d    = in_first ? s1_cur + prodx : s1_cur;
          s2_d    = in_first ? s2_cur : s2_cur + prodx;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_pos_q <= '0;
      phase_q     <= '0;
      s1_q        <= '0;
      s2_q        <= '0;
      wcount_q    <= '0;
      fin_vld_q   <= 1'b0;
    end else begin
      frame_pos_q <= frame_pos_d;
      phase_q     <= phase_d;
      s1_q        <= s1_d;
      s2_q        <= s2_d;
      wcount_q    <= wcount_d;
      fin_vld_q   <= fin_vld_d;
    end
  end

  // Final sums of a closing window, including its last sample.
  always_ff @(posedge clk_i) begin
    if (fin_vld_d) begin
      fin1_q    <= in_first ? s1_cur + prodx : s1_cur;
      fin2_q    <= in_first ? s2_cur : s2_cur + prodx;
      fin_idx_q <= wcount_cur;
    end
  end

  assign diff        = DIFF_W'(fin1_q) - DIFF_W'(fin2_q);
  assign push_o      = fin_vld_q;
  assign push_data_o = {fin_idx_q, diff};

endmodule
`default_nettype wire

// ===== rtl/whc_back.sv =====
// Back part: scales one window difference by shift-add multiply and restoring division.
`timescale 1ns / 1ps
`default_nettype none
module whc_back #(
  parameter int MAX_WAVE = 4096,
  localparam int Q_W    = $clog2(MAX_WAVE / 4 + 1),
  localparam int SUM_W  = 2 * $clog2(MAX_WAVE) + 19,
  localparam int DIFF_W = SUM_W + 1
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic [Q_W-1:0]               quarter_i,
  input  wire logic [whc_pkg::FREQ_W-1:0]   freq_i,
  input  wire whc_pkg::q_stat_t             q_stat_i,
  output logic                              pop_o,
  input  wire logic [whc_pkg::IDX_W+DIFF_W-1:0] pop_data_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output whc_pkg::out_item_t                out_data_o
);
  import whc_pkg::*;

  localparam int D_W   = Q_W + SCALE_W;
  localparam int P_W   = DIFF_W + FREQ_W;
  localparam int CM_W  = ((P_W > D_W + MAG_W) ? P_W : D_W + MAG_W);
  localparam int CNT_W = $clog2(MAG_W);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_CHK  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]        st_q, st_d;
  logic [P_W-1:0]    prod_q, mcand_q;
  logic [FREQ_W-1:0] fsh_q;
  logic [D_W-1:0]    div_q, rem_q;
  logic [MAG_W-1:0]  low_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [IDX_W-1:0]  idx_q;
  logic              out_vld_q;
  out_item_t         out_q;

  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]        ad;
  logic [P_W-1:0]           prod_hi;
  logic [D_W:0]             trial;
  logic                     take;
  logic                     load_out;
  logic                     sat;

  assign diff  = pop_data_i[DIFF_W-1:0];
  assign ad    = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
  assign pop_o = (st_q == ST_IDLE) && !q_stat_i.empty;

  // The quotient fits in the result width unless the product reaches divisor * 2^16.
  assign sat     = (CM_W'(prod_q) >= (CM_W'(div_q) << MAG_W));
  assign prod_hi = prod_q >> MAG_W;
  assign trial   = {rem_q, low_q[MAG_W-1]};
  assign take    = (trial >= (D_W + 1)'(div_q));
  assign load_out = (st_q == ST_DONE) && (!out_vld_q || out_ready_i);

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: if (pop_o) st_d = ST_MUL;
      ST_MUL:  if (fsh_q == '0) st_d = ST_CHK;
      ST_CHK:  st_d = sat ? ST_DONE : ST_DIV;
      ST_DIV:  if (cnt_q == CNT_W'(MAG_W - 1)) st_d = ST_DONE;
      ST_DONE: if (load_out) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      ST_IDLE: begin
        if (pop_o) begin
          prod_q  <= '0;
          mcand_q <= P_W'(ad);
          fsh_q   <= freq_i;
          idx_q   <= pop_data_i[DIFF_W +: IDX_W];
          div_q   <= D_W'(quarter_i) * D_W'(SCALE_DIV);
        end
      end
      ST_MUL: begin
        if (fsh_q != '0) begin
          if (fsh_q[0]) begin
            prod_q <= prod_q + mcand_q;
          end
          mcand_q <= mcand_q << 1;
          fsh_q   <= fsh_q >> 1;
        end
      end
      ST_CHK: begin
        rem_q <= prod_hi[D_W-1:0];
        low_q <= sat ? '1 : prod_q[MAG_W-1:0];
        cnt_q <= '0;
      end
      ST_DIV: begin
        rem_q <= take ? D_W'(trial - (D_W + 1)'(div_q)) : trial[D_W-1:0];
        low_q <= {low_q[MAG_W-2:0], take};
        cnt_q <= cnt_q + CNT_W'(1);
      end
      ST_DONE: begin
        if (load_out) begin
          out_q.magnitude    <= low_q;
          out_q.window_index <= idx_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  a_rem_below_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_DIV) |-> (rem_q < div_q))
    else $error("division remainder not below divisor");

  a_pop_starts_mul : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (st_q == ST_MUL))
    else $error("window taken from queue without starting the multiply");

endmodule
`default_nettype wire

// ===== rtl/windowed_halfwave_correlator.sv =====
// Top level: configuration registers, front accumulators, window queue and scaling unit.
// Throughput: one sample per cycle into the accumulators while the window queue has room;
// each emitted window then holds the scaling unit through its multiply, check and division
// (no division if it saturates), and the unit takes no new window until it is done; a result is
// delayed further when the four-entry window queue holds earlier windows or the output stalls.
// Reset clears frame position, window phase, sums, window count and the queue;
// one_wave, freq_hz and frame_len return to 441, 100 and 1000.
`timescale 1ns / 1ps
`default_nettype none
module windowed_halfwave_correlator #(
  parameter int MAX_WAVE  = 4096,
  parameter int MAX_FRAME = 1048576
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire whc_pkg::in_item_t               in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output whc_pkg::out_item_t                   out_data_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [whc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [whc_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import whc_pkg::*;

  localparam int WV_W   = $clog2(MAX_WAVE + 1);
  localparam int FP_W   = $clog2(MAX_FRAME + 1);
  localparam int Q_W    = $clog2(MAX_WAVE / 4 + 1);
  localparam int SUM_W  = 2 * $clog2(MAX_WAVE) + 19;
  localparam int DIFF_W = SUM_W + 1;

  logic [WAVE_CFG_W-1:0] one_wave_q;
  logic [FREQ_W-1:0]     freq_hz_q;
  logic [FLEN_CFG_W-1:0] frame_len_q;

  logic [31:0]     wave32, flen32;
  logic [WV_W-1:0] eff_wave, wave_sh;
  logic [FP_W-1:0] eff_flen;
  logic [Q_W-1:0]  quarter;

  q_stat_t                  q_stat;
  logic                     push, pop;
  logic [IDX_W+DIFF_W-1:0]  push_data, pop_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      one_wave_q  <= RST_ONE_WAVE;
      freq_hz_q   <= RST_FREQ_HZ;
      frame_len_q <= RST_FRAME_LEN;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_ONE_WAVE:  one_wave_q  <= cfg_data_i[WAVE_CFG_W-1:0];
        REG_FREQ_HZ:   freq_hz_q   <= cfg_data_i[FREQ_W-1:0];
        REG_FRAME_LEN: frame_len_q <= cfg_data_i[FLEN_CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Clamp the period into the supported range and the frame length to its maximum.
  always_comb begin
    priority if (32'(one_wave_q) < 32'(MIN_WAVE)) begin
      wave32 = 32'(MIN_WAVE);
    end else if (32'(one_wave_q) > 32'(MAX_WAVE)) begin
      wave32 = 32'(MAX_WAVE);
    end else begin
      wave32 = 32'(one_wave_q);
    end
    flen32 = (32'(frame_len_q) > 32'(MAX_FRAME)) ? 32'(MAX_FRAME) : 32'(frame_len_q);
  end

  assign eff_wave = wave32[WV_W-1:0];
  assign eff_flen = flen32[FP_W-1:0];
  assign wave_sh  = eff_wave >> 2;
  assign quarter  = wave_sh[Q_W-1:0];

  whc_front #(
    .MAX_WAVE  (MAX_WAVE),
    .MAX_FRAME (MAX_FRAME)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .wave_i      (eff_wave),
    .flen_i      (eff_flen),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .push_data_o (push_data)
  );

  whc_fifo #(
    .DATA_W (IDX_W + DIFF_W)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .stat_o      (q_stat)
  );

  whc_back #(
    .MAX_WAVE (MAX_WAVE)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .quarter_i   (quarter),
    .freq_i      (freq_hz_q),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .pop_data_i  (pop_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire
